// File: rtl/crt_pkg.sv
package crt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_PAIRS  = 16;
  localparam int WIDE_W     = 2 * VALUE_BITS;
  localparam int CNT_W      = $clog2(MAX_PAIRS + 2);
  localparam int IDX_W      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int STATUS_W   = 2;
  localparam int OP_W       = 5;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_NOT_COPRIME = 2'd1;
  localparam status_t ST_OVERFLOW    = 2'd2;
  localparam status_t ST_TOO_MANY    = 2'd3;

  typedef logic [OP_W-1:0] dp_op_t;
  localparam dp_op_t OP_NONE   = 5'd0;
  localparam dp_op_t OP_LOAD   = 5'd1;
  localparam dp_op_t OP_LDRES  = 5'd2;
  localparam dp_op_t OP_LDMUL  = 5'd3;
  localparam dp_op_t OP_STORE  = 5'd4;
  localparam dp_op_t OP_SINIT  = 5'd5;
  localparam dp_op_t OP_NEXT   = 5'd6;
  localparam dp_op_t OP_COFDIV = 5'd7;
  localparam dp_op_t OP_COF    = 5'd8;
  localparam dp_op_t OP_EINIT  = 5'd9;
  localparam dp_op_t OP_EDIV   = 5'd10;
  localparam dp_op_t OP_EQ     = 5'd11;
  localparam dp_op_t OP_EMUL   = 5'd12;
  localparam dp_op_t OP_ET     = 5'd13;
  localparam dp_op_t OP_TMUL   = 5'd14;
  localparam dp_op_t OP_TDIV   = 5'd15;
  localparam dp_op_t OP_TCMUL  = 5'd16;
  localparam dp_op_t OP_ACC    = 5'd17;
  localparam dp_op_t OP_NOINV  = 5'd18;
  localparam dp_op_t OP_FIN    = 5'd19;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic cnt_over;
    logic ovf;
    logic idx_end;
    logic mi_one;
    logic r1_zero;
    logic r0_one;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/crt_if.sv
interface crt_in_if;
  import crt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] residue;
  logic [VALUE_BITS-1:0] modulus;
  logic                  last;
  modport source (output valid, output residue, output modulus, output last, input ready);
  modport sink   (input valid, input residue, input modulus, input last, output ready);
endinterface

interface crt_out_if;
  import crt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] solution;
  logic [VALUE_BITS-1:0] product_modulus;
  logic [STATUS_W-1:0]   status;
  modport source (output valid, output solution, output product_modulus, output status,
                  input ready);
  modport sink   (input valid, input solution, input product_modulus, input status,
                  output ready);
endinterface

// File: rtl/crt_div.sv
module crt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [crt_pkg::WIDE_W-1:0]     dividend,
  input  logic [crt_pkg::VALUE_BITS-1:0] divisor,
  output logic [crt_pkg::WIDE_W-1:0]     quot,
  output logic [crt_pkg::VALUE_BITS-1:0] rem,
  output logic                           done
);
  import crt_pkg::*;

  localparam int STEP_W = $clog2(WIDE_W + 1);

  logic [WIDE_W-1:0]     quo_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] dvs_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic                  done_r;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS+1:0] diff;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem_r, quo_r[WIDE_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(WIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[VALUE_BITS+1]) begin
        rem_r <= diff[VALUE_BITS-1:0];
        quo_r <= {quo_r[WIDE_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[VALUE_BITS-1:0];
        quo_r <= {quo_r[WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// File: rtl/crt_ctrl.sv
module crt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crt_pkg::dp_stat_t stat,
  output crt_pkg::dp_cmd_t  cmd
);
  import crt_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LDIV = 5'd1;
  localparam logic [4:0] S_LMUL = 5'd2;
  localparam logic [4:0] S_LST  = 5'd3;
  localparam logic [4:0] S_CHK  = 5'd4;
  localparam logic [4:0] S_RD   = 5'd5;
  localparam logic [4:0] S_RW   = 5'd6;
  localparam logic [4:0] S_COF  = 5'd7;
  localparam logic [4:0] S_A    = 5'd8;
  localparam logic [4:0] S_EU   = 5'd9;
  localparam logic [4:0] S_EQ   = 5'd10;
  localparam logic [4:0] S_EM   = 5'd11;
  localparam logic [4:0] S_ET   = 5'd12;
  localparam logic [4:0] S_TM   = 5'd13;
  localparam logic [4:0] S_TD   = 5'd14;
  localparam logic [4:0] S_TW   = 5'd15;
  localparam logic [4:0] S_TS   = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_LDIV;
        end
      end
      S_LDIV: begin
        if (stat.div_done) begin
          cmd.op    = OP_LDRES;
          state_nxt = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd.op    = OP_LDMUL;
        state_nxt = S_LST;
      end
      S_LST: begin
        cmd.op    = OP_STORE;
        state_nxt = stat.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        cmd.op    = OP_SINIT;
        state_nxt = (stat.cnt_over || stat.ovf) ? S_FIN : S_RD;
      end
      S_RD: begin
        state_nxt = stat.idx_end ? S_FIN : S_RW;
      end
      S_RW: begin
        if (stat.mi_one) begin
          cmd.op    = OP_NEXT;
          state_nxt = S_RD;
        end else begin
          cmd.op    = OP_COFDIV;
          state_nxt = S_COF;
        end
      end
      S_COF: begin
        if (stat.div_done) begin
          cmd.op    = OP_COF;
          state_nxt = S_A;
        end
      end
      S_A: begin
        if (stat.div_done) begin
          cmd.op    = OP_EINIT;
          state_nxt = S_EU;
        end
      end
      S_EU: begin
        if (stat.r1_zero) begin
          if (stat.r0_one) begin
            state_nxt = S_TM;
          end else begin
            cmd.op    = OP_NOINV;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.op    = OP_EDIV;
          state_nxt = S_EQ;
        end
      end
      S_EQ: begin
        if (stat.div_done) begin
          cmd.op    = OP_EQ;
          state_nxt = S_EM;
        end
      end
      S_EM: begin
        cmd.op    = OP_EMUL;
        state_nxt = S_ET;
      end
      S_ET: begin
        cmd.op    = OP_ET;
        state_nxt = S_EU;
      end
      S_TM: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TD;
      end
      S_TD: begin
        cmd.op    = OP_TDIV;
        state_nxt = S_TW;
      end
      S_TW: begin
        if (stat.div_done) begin
          cmd.op    = OP_TCMUL;
          state_nxt = S_TS;
        end
      end
      S_TS: begin
        cmd.op    = OP_ACC;
        state_nxt = S_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/crt_dp.sv
module crt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crt_pkg::dp_cmd_t               cmd,
  output crt_pkg::dp_stat_t              stat,
  input  logic [crt_pkg::VALUE_BITS-1:0] in_residue,
  input  logic [crt_pkg::VALUE_BITS-1:0] in_modulus,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crt_pkg::VALUE_BITS-1:0] out_solution,
  output logic [crt_pkg::VALUE_BITS-1:0] out_product_modulus,
  output logic [crt_pkg::STATUS_W-1:0]   out_status
);
  import crt_pkg::*;

  localparam int VB = VALUE_BITS;

  // Pair store: residue in the upper half, modulus in the lower half.
  logic [WIDE_W-1:0] mem [MAX_PAIRS];
  logic [WIDE_W-1:0] rd_r;

  logic [VB-1:0]          m_r;
  logic [VB-1:0]          rr_r;
  logic                   last_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       idx_r;
  logic [VB-1:0]          rp_r;
  logic                   ovf_r;
  logic [VB-1:0]          cof_r;
  logic [VB-1:0]          r0_r;
  logic [VB-1:0]          r1_r;
  logic [VB-1:0]          q_r;
  logic signed [VB+1:0]   t0_r;
  logic signed [VB+1:0]   t1_r;
  logic signed [2*VB+2:0] mul_r;
  logic [VB-1:0]          sum_r;
  status_t                status_r;
  logic                   out_valid_r;
  logic [VB-1:0]          out_sol_r;
  logic [VB-1:0]          out_prod_r;
  status_t                out_status_r;

  logic [VB-1:0]        mi;
  logic [VB-1:0]        ri;
  logic [VB-1:0]        m_fix;
  logic signed [VB+1:0] inv_s;
  logic [VB-1:0]        inv;
  logic signed [VB:0]   mul_a;
  logic signed [VB+1:0] mul_b;
  logic [VB:0]          acc;
  logic                 div_start;
  logic [WIDE_W-1:0]    div_dividend;
  logic [VB-1:0]        div_divisor;
  logic [WIDE_W-1:0]    div_quot;
  logic [VB-1:0]        div_rem;
  logic                 div_done;

  assign mi    = rd_r[VB-1:0];
  assign ri    = rd_r[WIDE_W-1:VB];
  assign m_fix = (in_modulus == '0) ? VB'(1) : in_modulus;
  assign inv_s = t0_r[VB+1] ? (t0_r + $signed({2'b00, mi})) : t0_r;
  assign inv   = inv_s[VB-1:0];
  assign acc   = {1'b0, sum_r} + {1'b0, mul_r[VB-1:0]};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{VB{1'b0}}, in_residue};
    div_divisor  = m_fix;
    case (cmd.op)
      OP_LOAD: begin
        div_start = 1'b1;
      end
      OP_COFDIV: begin
        div_start    = 1'b1;
        div_dividend = {{VB{1'b0}}, rp_r};
        div_divisor  = mi;
      end
      OP_COF: begin
        div_start    = 1'b1;
        div_dividend = {{VB{1'b0}}, div_quot[VB-1:0]};
        div_divisor  = mi;
      end
      OP_EDIV: begin
        div_start    = 1'b1;
        div_dividend = {{VB{1'b0}}, r0_r};
        div_divisor  = r1_r;
      end
      OP_TDIV: begin
        div_start    = 1'b1;
        div_dividend = mul_r[WIDE_W-1:0];
        div_divisor  = mi;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a = $signed({1'b0, m_r});
    mul_b = $signed({2'b00, rp_r});
    case (cmd.op)
      OP_EMUL: begin
        mul_a = $signed({1'b0, q_r});
        mul_b = t1_r;
      end
      OP_TMUL: begin
        mul_a = $signed({1'b0, ri});
        mul_b = $signed({2'b00, inv});
      end
      OP_TCMUL: begin
        mul_a = $signed({1'b0, div_rem});
        mul_b = $signed({2'b00, cof_r});
      end
      default: begin
        mul_a = $signed({1'b0, m_r});
      end
    endcase
  end

  crt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && count_r < CNT_W'(MAX_PAIRS)) begin
      mem[count_r[IDX_W-1:0]] <= {rr_r, m_r};
    end
    rd_r <= mem[idx_r[IDX_W-1:0]];
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rp_r        <= VB'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_STORE: begin
          if (count_r < CNT_W'(MAX_PAIRS)) begin
            count_r <= count_r + CNT_W'(1);
            if (mul_r[WIDE_W-1:VB] != '0) begin
              ovf_r <= 1'b1;
            end else begin
              rp_r <= mul_r[VB-1:0];
            end
          end else begin
            count_r <= CNT_W'(MAX_PAIRS + 1);
          end
        end
        OP_FIN: begin
          out_valid_r <= 1'b1;
          count_r     <= '0;
          rp_r        <= VB'(1);
          ovf_r       <= 1'b0;
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE && cmd.op != OP_LOAD && cmd.op != OP_LDRES
        && cmd.op != OP_STORE && cmd.op != OP_COFDIV && cmd.op != OP_EDIV
        && cmd.op != OP_TDIV && cmd.op != OP_NOINV && cmd.op != OP_FIN
        && cmd.op != OP_ET && cmd.op != OP_EINIT && cmd.op != OP_COF
        && cmd.op != OP_ACC && cmd.op != OP_SINIT && cmd.op != OP_NEXT
        && cmd.op != OP_EQ) begin
      mul_r <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LOAD: begin
        m_r    <= m_fix;
        last_r <= in_last;
      end
      OP_LDRES: begin
        rr_r <= div_rem;
      end
      OP_SINIT: begin
        idx_r <= '0;
        sum_r <= '0;
        if (count_r > CNT_W'(MAX_PAIRS)) begin
          status_r <= ST_TOO_MANY;
        end else if (ovf_r) begin
          status_r <= ST_OVERFLOW;
        end else begin
          status_r <= ST_OK;
        end
      end
      OP_NEXT: begin
        idx_r <= idx_r + CNT_W'(1);
      end
      OP_COF: begin
        cof_r <= div_quot[VB-1:0];
      end
      OP_EINIT: begin
        r0_r <= mi;
        r1_r <= div_rem;
        t0_r <= '0;
        t1_r <= (VB+2)'(1);
      end
      OP_EQ: begin
        q_r  <= div_quot[VB-1:0];
        r0_r <= r1_r;
        r1_r <= div_rem;
      end
      OP_ET: begin
        t0_r <= t1_r;
        t1_r <= t0_r - $signed(mul_r[VB+1:0]);
      end
      OP_ACC: begin
        sum_r <= (acc >= {1'b0, rp_r}) ? VB'(acc - {1'b0, rp_r}) : acc[VB-1:0];
        idx_r <= idx_r + CNT_W'(1);
      end
      OP_NOINV: begin
        status_r <= ST_NOT_COPRIME;
      end
      OP_FIN: begin
        out_sol_r    <= (status_r == ST_OK) ? sum_r : '0;
        out_prod_r   <= rp_r;
        out_status_r <= status_r;
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

  assign stat.div_done = div_done;
  assign stat.last     = last_r;
  assign stat.cnt_over = count_r > CNT_W'(MAX_PAIRS);
  assign stat.ovf      = ovf_r;
  assign stat.idx_end  = idx_r == count_r;
  assign stat.mi_one   = mi == VB'(1);
  assign stat.r1_zero  = r1_r == '0;
  assign stat.r0_one   = r0_r == VB'(1);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_solution        = out_sol_r;
  assign out_product_modulus = out_prod_r;
  assign out_status          = out_status_r;

`ifndef NO_ASSERTIONS
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |=> (count_r == '0 && rp_r == VB'(1) && !ovf_r && out_valid_r))
    else $error("system state not cleared after result");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAIRS + 1))
    else $error("pair count out of range");
  a_sum_below_product: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_ACC |=> sum_r < rp_r)
    else $error("running sum not reduced below product");
  a_no_fin_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
`endif

endmodule

// File: rtl/crt_solver_core.sv
// Channel    | Direction | Word contents
// -----------+-----------+------------------------------------------------
// in_word    | sink      | residue, modulus, last (one congruence)
// out_word   | source    | solution, product_modulus, status (one system)
//
// To load a pair, a 62-step bit-serial division reduces the residue,
// then a multiply forms the product and a store step writes it.
// After the pair marked last, every modulus other than one costs, when it has
// an inverse, three divisions plus one per extended-Euclid step, all on the
// single shared divider; that divider sets the pace of the whole block.
// Reset is synchronous and active low; the pair store holds no reset value.
// A finished result waits in the output register while the next system loads.
module crt_solver_core (
  input logic      clk,
  input logic      rst_n,
  crt_in_if.sink   in_word,
  crt_out_if.source out_word
);
  import crt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences loading and solving; the datapath holds the pair
  // store, the running product, the Euclid registers, one multiplier and the
  // shared divider.
  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_residue          (in_word.residue),
    .in_modulus          (in_word.modulus),
    .in_last             (in_word.last),
    .out_valid           (out_word.valid),
    .out_ready           (out_word.ready),
    .out_solution        (out_word.solution),
    .out_product_modulus (out_word.product_modulus),
    .out_status          (out_word.status)
  );

endmodule
